### hdl/pfp_pkg.sv
// ----------------------------------------------------------------------------
// pfp_pkg
// Shared types for the prime-first partition block: channel payloads,
// sequencer and tester states, and the primality tester's status bundle.
// ----------------------------------------------------------------------------
package pfp_pkg;

  localparam int ELEM_W = 16;

  typedef struct packed {
    logic [ELEM_W-1:0] value;
    logic              final_element;
  } pfp_in_t;

  typedef struct packed {
    logic [ELEM_W-1:0] element;
    logic              end_of_set;
  } pfp_out_t;

  // status from the primality tester
  typedef struct packed {
    logic done;   // one-cycle pulse
    logic prime;  // valid with done
  } pfp_test_res_t;

  typedef enum logic [1:0] {
    PT_IDLE,
    PT_CHECK,
    PT_DIV
  } pfp_pt_state_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_LO_RD,
    S_LO_START,
    S_LO_TEST,
    S_HI_RD,
    S_HI_START,
    S_HI_TEST,
    S_SWAP_LO,
    S_SWAP_HI,
    S_EM_RD,
    S_EM_OUT
  } pfp_state_t;

endpackage

### hdl/pfp_prime_test.sv
// ----------------------------------------------------------------------------
// pfp_prime_test
// Iterative trial-division primality test. Divisors run from 2 while
// d*d <= v; each remainder comes from a bit-serial restoring divider.
// ----------------------------------------------------------------------------
module pfp_prime_test
  import pfp_pkg::*;
#(
  parameter int SW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [SW-1:0] operand,
  output pfp_test_res_t res
);

  localparam int SQW = SW + 2;
  localparam int BW  = (SW > 1) ? $clog2(SW) : 1;

  pfp_pt_state_t state_r, state_nxt;

  logic [SW-1:0]  v_r,   v_nxt;
  logic [SW-1:0]  d_r,   d_nxt;
  logic [SQW-1:0] sq_r,  sq_nxt;
  logic [SW-1:0]  rem_r, rem_nxt;
  logic [BW-1:0]  bit_r, bit_nxt;
  logic           done_r, done_nxt;
  logic           prime_r, prime_nxt;

  logic [SW:0]    rem_sh;
  logic [SW:0]    rem_sub;
  logic [SW-1:0]  rem_step;

  always_comb begin
    rem_sh   = {rem_r, v_r[bit_r]};
    rem_sub  = rem_sh - {1'b0, d_r};
    rem_step = (rem_sh >= {1'b0, d_r}) ? rem_sub[SW-1:0] : rem_sh[SW-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    v_nxt     = v_r;
    d_nxt     = d_r;
    sq_nxt    = sq_r;
    rem_nxt   = rem_r;
    bit_nxt   = bit_r;
    done_nxt  = 1'b0;
    prime_nxt = prime_r;
    case (state_r)
      PT_IDLE: begin
        if (start) begin
          v_nxt = operand;
          if (operand <= SW'(1)) begin
            done_nxt  = 1'b1;
            prime_nxt = 1'b0;
          end else begin
            d_nxt     = SW'(2);
            sq_nxt    = SQW'(4);
            state_nxt = PT_CHECK;
          end
        end
      end
      PT_CHECK: begin
        if (sq_r > {2'b00, v_r}) begin
          done_nxt  = 1'b1;
          prime_nxt = 1'b1;
          state_nxt = PT_IDLE;
        end else begin
          rem_nxt   = '0;
          bit_nxt   = BW'(SW - 1);
          state_nxt = PT_DIV;
        end
      end
      PT_DIV: begin
        rem_nxt = rem_step;
        if (bit_r == '0) begin
          if (rem_step == '0) begin
            done_nxt  = 1'b1;
            prime_nxt = 1'b0;
            state_nxt = PT_IDLE;
          end else begin
            // (d+1)^2 = d^2 + 2d + 1
            sq_nxt    = sq_r + {1'b0, d_r, 1'b0} + SQW'(1);
            d_nxt     = d_r + SW'(1);
            state_nxt = PT_CHECK;
          end
        end else begin
          bit_nxt = bit_r - BW'(1);
        end
      end
      default: state_nxt = PT_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PT_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r     <= v_nxt;
    d_r     <= d_nxt;
    sq_r    <= sq_nxt;
    rem_r   <= rem_nxt;
    bit_r   <= bit_nxt;
    prime_r <= prime_nxt;
  end

  assign res.done  = done_r;
  assign res.prime = prime_r;

endmodule

### hdl/prime_first_partition.sv
// ----------------------------------------------------------------------------
// prime_first_partition
// Buffers a set of values, partitions it in place so primes come first,
// then streams the whole set back out with the last element flagged.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+------------------------------------
//  in_     | in  | in_valid/in_stall | pfp_in_t  {value, final_element}
//  out_    | out | out_valid/out_stall | pfp_out_t {element, end_of_set}
//
//  Loading takes one cycle per input transaction. After a final element the
//  input stalls while the set is partitioned and emitted: each element
//  visited costs a buffer read plus the primality test, which for v <= 1
//  answers without dividing and otherwise runs trial divisions on the
//  bit-serial divider. A swap adds two buffer writes. Emission reads each
//  result through the one read port before it is registered on the output.
//  Reset (rst_n, synchronous) clears the fill count, sequencer and output
//  valid flag; buffer contents are left undefined and are never read before being written.
//  out_stall holds the output register; the next set may load while the
//  last result of the previous one still waits.
// ----------------------------------------------------------------------------
module prime_first_partition
  import pfp_pkg::*;
#(
  parameter int MAX_ELEMENTS = 32,
  parameter int VALUE_BITS   = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  pfp_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output pfp_out_t out_data
);

  // stored value width: only the low min(VALUE_BITS,16) bits of a 16-bit field survive
  localparam int SW = (VALUE_BITS < ELEM_W) ? VALUE_BITS : ELEM_W;
  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int CW = $clog2(MAX_ELEMENTS + 1);

  pfp_state_t state_r, state_nxt;

  logic [CW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] lo_r,   lo_nxt;
  logic [AW-1:0] hi_r,   hi_nxt;
  logic [AW-1:0] k_r,    k_nxt;
  logic [SW-1:0] lo_val_r, lo_val_nxt;
  logic [SW-1:0] hi_val_r, hi_val_nxt;

  logic          out_valid_r, out_valid_nxt;
  pfp_out_t      out_data_r,  out_data_nxt;

  // buffer memory: one write port, one registered read port
  logic [SW-1:0] mem [MAX_ELEMENTS];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [SW-1:0] mem_wdata;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [SW-1:0] rdata_r;

  logic          test_start;
  pfp_test_res_t test_res;

  logic          in_acc;
  logic          out_free;
  logic          k_last;
  logic [CW-1:0] fill_inc;

  pfp_prime_test #(
    .SW (SW)
  ) u_test (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (test_start),
    .operand (rdata_r),
    .res     (test_res)
  );

  assign in_stall = (state_r != S_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign k_last   = ((CW'(k_r) + CW'(1)) == fill_r);
  assign fill_inc = fill_r + CW'(1);

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    k_nxt         = k_r;
    lo_val_nxt    = lo_val_r;
    hi_val_nxt    = hi_val_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    mem_we        = 1'b0;
    mem_waddr     = fill_r[AW-1:0];
    mem_wdata     = in_data.value[SW-1:0];
    rd_en         = 1'b0;
    rd_addr       = lo_r;
    test_start    = 1'b0;

    case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          // full buffer drops the value but still honors the final flag
          if (fill_r < CW'(MAX_ELEMENTS)) begin
            mem_we   = 1'b1;
            fill_nxt = fill_inc;
          end
          if (in_data.final_element) begin
            lo_nxt = '0;
            k_nxt  = '0;
            if (fill_r < CW'(MAX_ELEMENTS)) begin
              hi_nxt = fill_r[AW-1:0];
            end else begin
              hi_nxt = AW'(MAX_ELEMENTS - 1);
            end
            state_nxt = S_LO_RD;
          end
        end
      end
      S_LO_RD: begin
        if (lo_r < hi_r) begin
          rd_en     = 1'b1;
          rd_addr   = lo_r;
          state_nxt = S_LO_START;
        end else begin
          state_nxt = S_EM_RD;
        end
      end
      S_LO_START: begin
        test_start = 1'b1;
        lo_val_nxt = rdata_r;
        state_nxt  = S_LO_TEST;
      end
      S_LO_TEST: begin
        if (test_res.done) begin
          if (test_res.prime) begin
            lo_nxt    = lo_r + AW'(1);
            state_nxt = S_LO_RD;
          end else begin
            state_nxt = S_HI_RD;
          end
        end
      end
      S_HI_RD: begin
        if (lo_r < hi_r) begin
          rd_en     = 1'b1;
          rd_addr   = hi_r;
          state_nxt = S_HI_START;
        end else begin
          state_nxt = S_EM_RD;
        end
      end
      S_HI_START: begin
        test_start = 1'b1;
        hi_val_nxt = rdata_r;
        state_nxt  = S_HI_TEST;
      end
      S_HI_TEST: begin
        if (test_res.done) begin
          if (test_res.prime) begin
            state_nxt = S_SWAP_LO;
          end else begin
            hi_nxt    = hi_r - AW'(1);
            state_nxt = S_HI_RD;
          end
        end
      end
      S_SWAP_LO: begin
        mem_we    = 1'b1;
        mem_waddr = lo_r;
        mem_wdata = hi_val_r;
        state_nxt = S_SWAP_HI;
      end
      S_SWAP_HI: begin
        mem_we    = 1'b1;
        mem_waddr = hi_r;
        mem_wdata = lo_val_r;
        lo_nxt    = lo_r + AW'(1);
        hi_nxt    = hi_r - AW'(1);
        state_nxt = S_LO_RD;
      end
      S_EM_RD: begin
        rd_en     = 1'b1;
        rd_addr   = k_r;
        state_nxt = S_EM_OUT;
      end
      S_EM_OUT: begin
        // rdata_r holds until the output register frees up
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_data_nxt.element = ELEM_W'(rdata_r);
          out_data_nxt.end_of_set = k_last;
          if (k_last) begin
            fill_nxt  = '0;
            state_nxt = S_LOAD;
          end else begin
            k_nxt     = k_r + AW'(1);
            state_nxt = S_EM_RD;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    k_r        <= k_nxt;
    lo_val_r   <= lo_val_nxt;
    hi_val_r   <= hi_val_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
